[design/pdv_pkg.sv]
// shared types, character constants and classification function for the percent decoder
`default_nettype none

package pdv_pkg;

  // queue depths
  localparam int PDV_QUEUE_DEPTH  = 4;
  localparam int PDV_RESULT_DEPTH = 2;

  // characters of interest
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] HEX_OFFSET = 8'd10;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } pdv_in_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       end_of_string;
  } pdv_out_t;

  // classified character handed from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic       is_pct;
    logic       is_unres;
    logic       hex_ok;
    logic [3:0] nibble;
    logic       last;
  } pdv_class_t;

  // sort one character into its classes and hex value
  function automatic pdv_class_t pdv_classify(input pdv_in_t w);
    pdv_class_t c;
    logic       dig;
    logic       up;
    logic       lo;
    logic [7:0] d;
    dig = (w.in_byte >= CH_0) && (w.in_byte <= CH_9);
    up  = (w.in_byte >= CH_UA) && (w.in_byte <= CH_UZ);
    lo  = (w.in_byte >= CH_LA) && (w.in_byte <= CH_LZ);
    c.raw      = w.in_byte;
    c.last     = w.is_last;
    c.is_pct   = (w.in_byte == CH_PERCENT);
    c.is_unres = dig || up || lo || (w.in_byte == CH_DASH) || (w.in_byte == CH_UNDER) ||
                 (w.in_byte == CH_DOT) || (w.in_byte == CH_TILDE);
    c.hex_ok   = 1'b1;
    if (dig) begin
      d = w.in_byte - CH_0;
    end else if ((w.in_byte >= CH_UA) && (w.in_byte <= CH_UF)) begin
      d = w.in_byte - CH_UA + HEX_OFFSET;
    end else if ((w.in_byte >= CH_LA) && (w.in_byte <= CH_LF)) begin
      d = w.in_byte - CH_LA + HEX_OFFSET;
    end else begin
      d = 8'd0;
      c.hex_ok = 1'b0;
    end
    c.nibble = d[3:0];
    return c;
  endfunction

endpackage

`default_nettype wire

[design/pdv_fifo.sv]
// small register queue with simultaneous write and read
`default_nettype none

module pdv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_write_fills: assert property (@(posedge clk) disable iff (rst) wr && !rd |=> !empty)
    else $error("queue empty after a write");
`endif

endmodule

`default_nettype wire

[design/pdv_front.sv]
// front end: accepts input words and classifies each character
`default_nettype none

module pdv_front
  import pdv_pkg::*;
(
  input  wire logic       push,
  input  wire pdv_in_t    item,
  input  wire logic       q_full,
  output logic            q_wr,
  output pdv_class_t      q_data
);

  // accept when the queue has room
  assign q_wr   = push && !q_full;
  assign q_data = pdv_classify(item);

endmodule

`default_nettype wire

[design/pdv_back.sv]
// back end: escape state machine producing one result per character
`default_nettype none

module pdv_back
  import pdv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pdv_class_t q_data,
  input  wire logic       q_empty,
  output logic            q_rd,
  input  wire logic       o_full,
  output logic            o_wr,
  output pdv_out_t        o_data
);

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       error_seen;
  logic       error_seen_next;
  logic       step;

  assign step = !q_empty && !o_full;
  assign q_rd = step;
  assign o_wr = step;

  // decode step
  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    error_seen_next  = error_seen;
    o_data.out_byte   = 8'd0;
    o_data.byte_valid = 1'b0;
    if (!error_seen) begin
      unique case (phase)
        PH_HIGH: begin
          if (!q_data.hex_ok || q_data.last) begin
            error_seen_next = 1'b1;
          end else begin
            high_nibble_next = q_data.nibble;
            phase_next       = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!q_data.hex_ok) begin
            error_seen_next = 1'b1;
          end else begin
            o_data.out_byte   = {high_nibble, q_data.nibble};
            o_data.byte_valid = 1'b1;
            phase_next        = PH_NORMAL;
          end
        end
        default: begin
          if (q_data.is_pct) begin
            if (q_data.last) begin
              error_seen_next = 1'b1;
            end else begin
              phase_next = PH_HIGH;
            end
          end else if (q_data.is_unres) begin
            o_data.out_byte   = q_data.raw;
            o_data.byte_valid = 1'b1;
            phase_next        = PH_NORMAL;
          end else begin
            error_seen_next = 1'b1;
          end
        end
      endcase
    end
    o_data.status        = error_seen_next;
    o_data.end_of_string = q_data.last;
  end

  // state registers, cleared after each last character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      high_nibble <= 4'd0;
      error_seen  <= 1'b0;
    end else if (step) begin
      if (q_data.last) begin
        phase       <= PH_NORMAL;
        high_nibble <= 4'd0;
        error_seen  <= 1'b0;
      end else begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        error_seen  <= error_seen_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
      o_wr && o_data.byte_valid |-> !o_data.status)
    else $error("decoded byte emitted with error status");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      step && q_data.last |=> phase == PH_NORMAL && !error_seen)
    else $error("state not cleared after last character");
`endif

endmodule

`default_nettype wire

[design/percent_decoder_validator.sv]
// top level of the streaming percent decoder and validator
//
// Usage: characters of an encoded string enter as words on the input queue
// port (push/full, accepted when push is high and full is low); item.is_last
// marks the last character of each string. Every character yields exactly one
// result word on the output queue port (empty/pop, taken when pop is high and
// empty is low): a decoded byte with byte_valid, the sticky error status of
// the string so far, and end_of_string on the last character's result.
// Each accepted character is registered in both queues before it is popped.
// Throughput: one character per cycle while the classification queue is
// not empty and the result queue is not full. A classification queue of
// QUEUE_DEPTH words lets the front keep accepting while the back waits on a
// full result queue of RESULT_DEPTH words; when the receiver stalls both
// fill and then full rises. Reset (rst, synchronous) empties both queues
// and returns the back end's escape state machine to normal with no error.
`default_nettype none

module percent_decoder_validator
  import pdv_pkg::*;
#(
  parameter int QUEUE_DEPTH  = PDV_QUEUE_DEPTH,
  parameter int RESULT_DEPTH = PDV_RESULT_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire pdv_in_t  item,
  output logic          empty,
  input  wire logic     pop,
  output pdv_out_t      result
);

  logic       q_wr;
  logic       q_rd;
  logic       q_full;
  logic       q_empty;
  pdv_class_t q_wdata;
  pdv_class_t q_rdata;
  logic       o_wr;
  logic       o_full;
  pdv_out_t   o_wdata;

  assign full = q_full;

  // classify incoming characters
  pdv_front u_front (
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  // classified words between front and back
  pdv_fifo #(
    .WIDTH ($bits(pdv_class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_class_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // decode state machine
  pdv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .o_full  (o_full),
    .o_wr    (o_wr),
    .o_data  (o_wdata)
  );

  // result queue toward the receiver
  pdv_fifo #(
    .WIDTH ($bits(pdv_out_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (o_wr),
    .wdata (o_wdata),
    .rd    (pop && !empty),
    .rdata (result),
    .full  (o_full),
    .empty (empty)
  );

endmodule

`default_nettype wire
